FILE: rtl/core/iyrgb_pkg.sv
// ----------------------------------------------------------------------------
// iyrgb_pkg
// Shared constants, types and helpers of the interleaved 4:2:0 to RGB block.
// ----------------------------------------------------------------------------
`default_nettype none

package iyrgb_pkg;

    // line geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int GROUP_DEPTH = MAX_WIDTH / 4;
    localparam int GROUP_W     = $clog2(GROUP_DEPTH);
    localparam int GROUPS_W    = GROUP_W + 1;
    localparam int EFFW_W      = $clog2(MAX_WIDTH + 1);
    localparam int COL_FULL_W  = GROUP_W + 2;

    // register file
    localparam int CFG_W       = 11;
    localparam int CFG_ADDR_W  = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH   = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // position inside a six byte group
    localparam logic [2:0] BYTE_FIRST_CHROMA = 3'd4;
    localparam logic [2:0] BYTE_LAST         = 3'd5;

    // field widths
    localparam int LINE_W     = 10;
    localparam int ROW_PAIR_W = 9;
    localparam int COLUMN_W   = 10;

    // one stored even-line group: four luma bytes then two U bytes
    localparam int GROUP_WORD_W = 48;

    // everything needed to produce the eight pixels of one group pair
    typedef struct packed {
        logic [GROUP_WORD_W-1:0] even_word;   // even luma 0..3, u0, u1
        logic [39:0]             odd_word;    // odd luma 0..3, v0
        logic [7:0]              v1;
        logic [GROUP_W-1:0]      group;
        logic [ROW_PAIR_W-1:0]   row_pair;
        logic                    frame_end;
    } emit_t;

    // clamp a floored channel value to 0..255
    function automatic logic [7:0] clamp8(input logic signed [18:0] acc);
        logic signed [10:0] v;
        v = acc[18:8];
        if (v < 0)
            return 8'd0;
        if (v > 11'sd255)
            return 8'd255;
        return v[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/iyrgb_ram.sv
// ----------------------------------------------------------------------------
// iyrgb_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module iyrgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/iyrgb_parser.sv
// ----------------------------------------------------------------------------
// iyrgb_parser
// Byte position tracking, even-line group store and group pair capture.
// ----------------------------------------------------------------------------
`default_nettype none

module iyrgb_parser (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [iyrgb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [iyrgb_pkg::CFG_W-1:0]      cfg_wdata,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [7:0]                       in_byte,
    input  wire logic                             in_sof,
    input  wire logic                             emit_busy,
    output logic                                  emit_load,
    output iyrgb_pkg::emit_t                      emit_data
);

    import iyrgb_pkg::*;

    logic [CFG_W-1:0]   line_width_reg;
    logic [CFG_W-1:0]   frame_height_reg;
    logic [2:0]         byte_reg;
    logic [GROUP_W-1:0] group_reg;
    logic               parity_reg;
    logic [LINE_W-1:0]  line_reg;
    logic [39:0]        hold_reg;

    logic [2:0]         byte_cur;
    logic [GROUP_W-1:0] group_cur;
    logic               parity_cur;
    logic [LINE_W-1:0]  line_cur;

    logic [2:0]         byte_next;
    logic [GROUP_W-1:0] group_next;
    logic               parity_next;
    logic [LINE_W-1:0]  line_next;

    logic [EFFW_W-1:0]   eff_width;
    logic [GROUPS_W-1:0] groups;
    logic [CFG_W-1:0]    eff_height;
    logic                last_group;
    logic                last_line;
    logic                frame_end;
    logic                accept;
    logic                ram_we;
    logic [GROUP_WORD_W-1:0] ram_rdata;
    logic [LINE_W:0]     line_inc;

    // effective geometry from the registers
    always_comb begin
        if (line_width_reg < CFG_W'(4))
            eff_width = EFFW_W'(4);
        else if (32'(line_width_reg) > MAX_WIDTH)
            eff_width = EFFW_W'(MAX_WIDTH);
        else
            eff_width = EFFW_W'(line_width_reg);
        eff_width[1:0] = 2'b00;
        groups = GROUPS_W'(eff_width[EFFW_W-1:2]);

        if (frame_height_reg < CFG_W'(2))
            eff_height = CFG_W'(2);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            eff_height = CFG_W'(MAX_HEIGHT);
        else
            eff_height = frame_height_reg;
    end

    // position of the byte on the bus, start of frame restarts at line 0
    always_comb begin
        if (in_sof) begin
            byte_cur   = '0;
            group_cur  = '0;
            parity_cur = 1'b0;
            line_cur   = '0;
        end else begin
            byte_cur   = byte_reg;
            group_cur  = group_reg;
            parity_cur = parity_reg;
            line_cur   = line_reg;
        end
    end

    // end of line and end of frame tests
    always_comb begin
        line_inc   = {1'b0, line_cur} + (LINE_W+1)'(1);
        last_group = (GROUPS_W'(group_cur) + GROUPS_W'(1)) >= groups;
        last_line  = CFG_W'(line_inc) >= eff_height;
        frame_end  = last_group && (CFG_W'(line_inc) + CFG_W'(1) >= eff_height);
    end

    // counter advance after the byte
    always_comb begin
        byte_next   = byte_cur + 3'd1;
        group_next  = group_cur;
        parity_next = parity_cur;
        line_next   = line_cur;
        if (byte_cur >= BYTE_LAST) begin
            byte_next = '0;
            if (last_group) begin
                group_next = '0;
                if (last_line) begin
                    line_next   = '0;
                    parity_next = 1'b0;
                end else begin
                    line_next   = line_inc[LINE_W-1:0];
                    parity_next = line_inc[0];
                end
            end else begin
                group_next = group_cur + GROUP_W'(1);
            end
        end
    end

    // odd-line sixth byte needs the emitter free; tested on stored position
    assign in_ready  = !(parity_reg && (byte_reg == BYTE_LAST) && emit_busy);
    assign accept    = in_valid && in_ready;
    assign emit_load = accept && parity_cur && (byte_cur == BYTE_LAST);
    assign ram_we    = accept && !parity_cur && (byte_cur == BYTE_LAST);

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_LINE_WIDTH:   line_width_reg   <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg   <= '0;
            group_reg  <= '0;
            parity_reg <= 1'b0;
            line_reg   <= '0;
        end else if (accept) begin
            byte_reg   <= byte_next;
            group_reg  <= group_next;
            parity_reg <= parity_next;
            line_reg   <= line_next;
        end
    end

    // group byte hold: luma bytes and first chroma byte of either line
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= '0;
        end else if (accept && (byte_cur <= BYTE_FIRST_CHROMA)) begin
            hold_reg[byte_cur*8 +: 8] <= in_byte;
        end
    end

    // even-line store, one word per group; read address follows the group
    iyrgb_ram #(
        .WIDTH (GROUP_WORD_W),
        .DEPTH (GROUP_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (group_cur),
        .wdata ({in_byte, hold_reg}),
        .raddr (group_reg),
        .rdata (ram_rdata)
    );

    // capture bundle for the emitter
    always_comb begin
        emit_data.even_word = ram_rdata;
        emit_data.odd_word  = hold_reg;
        emit_data.v1        = in_byte;
        emit_data.group     = group_cur;
        emit_data.row_pair  = line_cur[LINE_W-1:1];
        emit_data.frame_end = frame_end;
    end

endmodule

`default_nettype wire

FILE: rtl/core/iyrgb_emitter.sv
// ----------------------------------------------------------------------------
// iyrgb_emitter
// Converts a group pair into eight RGB pixels, one per cycle when not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module iyrgb_emitter (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             load,
    input  wire iyrgb_pkg::emit_t                 load_data,
    output logic                                  busy,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [7:0]                            out_red,
    output logic [7:0]                            out_green,
    output logic [7:0]                            out_blue,
    output logic                                  out_odd_row,
    output logic [iyrgb_pkg::COLUMN_W-1:0]        out_column,
    output logic [iyrgb_pkg::ROW_PAIR_W-1:0]      out_row_pair,
    output logic                                  out_last,
    output logic                                  out_eof
);

    import iyrgb_pkg::*;

    localparam logic signed [18:0] C_RV  = 19'sd359;
    localparam logic signed [18:0] C_GU  = 19'sd88;
    localparam logic signed [18:0] C_GV  = 19'sd183;
    localparam logic signed [18:0] C_BU  = 19'sd454;
    localparam logic signed [18:0] C_MID = 19'sd128;

    emit_t      pair_reg;
    logic       busy_reg;
    logic [2:0] cnt_reg;
    logic       valid_reg;
    logic [7:0] red_reg, green_reg, blue_reg;
    logic       odd_reg, last_reg, eof_reg;
    logic [COLUMN_W-1:0]   col_reg;
    logic [ROW_PAIR_W-1:0] row_reg;

    logic        adv;
    logic        row;
    logic [1:0]  k;
    logic [7:0]  y, u, v;
    logic signed [18:0] yy, cu, cv;
    logic signed [18:0] r_acc, g_acc, b_acc;
    logic [COL_FULL_W-1:0] col_full;

    assign adv = busy_reg && (!valid_reg || out_ready);

    // select luma and chroma of the current pixel
    always_comb begin
        row = cnt_reg[2];
        k   = cnt_reg[1:0];
        if (row)
            y = pair_reg.odd_word[k*8 +: 8];
        else
            y = pair_reg.even_word[k*8 +: 8];
        u = pair_reg.even_word[(4 + k[1])*8 +: 8];
        v = k[1] ? pair_reg.v1 : pair_reg.odd_word[39:32];
        col_full = {pair_reg.group, k};
    end

    // color conversion
    always_comb begin
        yy    = $signed({3'b000, y, 8'b0});
        cu    = $signed({11'b0, u}) - C_MID;
        cv    = $signed({11'b0, v}) - C_MID;
        r_acc = yy + C_RV * cv;
        g_acc = yy - C_GU * cu - C_GV * cv;
        b_acc = yy + C_BU * cu;
    end

    // sequencing of the eight pixels
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (adv) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                    busy_reg <= 1'b0;
            end
            if (adv)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // capture of the group pair
    always_ff @(posedge aclk) begin
        if (load)
            pair_reg <= load_data;
    end

    // output register
    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg   <= clamp8(r_acc);
            green_reg <= clamp8(g_acc);
            blue_reg  <= clamp8(b_acc);
            odd_reg   <= row;
            col_reg   <= COLUMN_W'(col_full);
            row_reg   <= pair_reg.row_pair;
            last_reg  <= (cnt_reg == 3'd7);
            eof_reg   <= (cnt_reg == 3'd7) && pair_reg.frame_end;
        end
    end

    assign busy         = busy_reg;
    assign out_valid    = valid_reg;
    assign out_red      = red_reg;
    assign out_green    = green_reg;
    assign out_blue     = blue_reg;
    assign out_odd_row  = odd_reg;
    assign out_column   = col_reg;
    assign out_row_pair = row_reg;
    assign out_last     = last_reg;
    assign out_eof      = eof_reg;

endmodule

`default_nettype wire

FILE: rtl/core/interleaved_yuv420_to_rgb.sv
// ----------------------------------------------------------------------------
// interleaved_yuv420_to_rgb
// Interleaved 4:2:0 camera byte stream to RGB pixel stream.
//
// The slave channel takes one raw byte per transfer, tuser marking the first
// byte of a frame. Lines are groups of four luma and two chroma bytes; even
// lines are kept in an on-chip group store, one word per group. On the last
// byte of an odd-line group the block captures the group pair and sends eight
// pixels on the master channel: four of the even row, then four of the odd
// row. tlast marks the eighth pixel, tuser the last pixel of the frame.
// The group pair is captured in the emitter's pair register and each pixel
// then leaves from its output register, one per cycle while the receiver is
// ready. The next odd-line group's last byte waits until the eighth pixel has
// entered the output register; bytes of even lines flow one per cycle.
// s_tready drops only on the last byte of an odd-line group while the
// previous eight pixels are still being sent, and a stalled receiver holds
// the pixel in the output register. Reset sets line_width to 640, frame_height
// to 480 and the position to the frame's first byte; the group store is not
// cleared. The register port writes at once, with no read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module interleaved_yuv420_to_rgb (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // register write port
    input  wire logic                             cfg_we,
    input  wire logic [iyrgb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [iyrgb_pkg::CFG_W-1:0]      cfg_wdata,
    // byte input
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,  // data_byte
    input  wire logic                             s_tuser,  // start_of_frame
    // pixel output
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [47:0]                           m_tdata,  // red, green, blue, odd_row,
                                                            // column, row_pair, zero pad
    output logic                                  m_tlast,  // last_of_run
    output logic                                  m_tuser   // end_of_frame
);

    import iyrgb_pkg::*;

    logic                  emit_busy;
    logic                  emit_load;
    emit_t                 emit_data;
    logic [7:0]            red, green, blue;
    logic                  odd_row;
    logic [COLUMN_W-1:0]   column;
    logic [ROW_PAIR_W-1:0] row_pair;

    // byte parsing and even-line store
    iyrgb_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_sof    (s_tuser),
        .emit_busy (emit_busy),
        .emit_load (emit_load),
        .emit_data (emit_data)
    );

    // pixel conversion and output register
    iyrgb_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (emit_load),
        .load_data    (emit_data),
        .busy         (emit_busy),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_red      (red),
        .out_green    (green),
        .out_blue     (blue),
        .out_odd_row  (odd_row),
        .out_column   (column),
        .out_row_pair (row_pair),
        .out_last     (m_tlast),
        .out_eof      (m_tuser)
    );

    // pack pixel fields from the lowest bit up
    assign m_tdata = {4'b0000, row_pair, column, odd_row, blue, green, red};

endmodule

`default_nettype wire

FILE: test/rgb_pixel_checker.sv
// ----------------------------------------------------------------------------
// rgb_pixel_checker
// Watches the byte and pixel channels of interleaved_yuv420_to_rgb, predicts
// the pixels of every accepted byte and compares each pixel transfer, field
// by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module rgb_pixel_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [iyrgb_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [iyrgb_pkg::CFG_W-1:0]      cfg_wdata,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // data_byte
    input  logic                             s_tuser,  // start_of_frame
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [47:0]                      m_tdata,  // red, green, blue, odd_row,
                                                       // column, row_pair, zero pad
    input  logic                             m_tlast,  // last_of_run
    input  logic                             m_tuser,  // end_of_frame
    output int                               pixel_errors,
    output int                               pixels_outstanding
);
    import iyrgb_pkg::*;

    typedef struct {
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic                  odd_row;
        logic [COLUMN_W-1:0]   column;
        logic [ROW_PAIR_W-1:0] row_pair;
        logic                  last_of_run;
        logic                  end_of_frame;
    } rgb_pixel_t;

    rgb_pixel_t predicted_pixels[$];

    // register copies
    logic [CFG_W-1:0] line_width;
    logic [CFG_W-1:0] frame_height;

    // stored even line and the odd-line group being collected
    logic [7:0]  even_luma[MAX_WIDTH];
    logic [7:0]  even_u[MAX_WIDTH/2];
    logic [31:0] odd_luma;
    logic [7:0]  first_v;

    // position in the frame
    int byte_pos;
    int group_idx;
    int line_idx;
    bit line_odd;

    int pixels_seen;

    function automatic int active_width();
        int w;
        w = line_width;
        if (w < 4)
            w = 4;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        return w & ~3;
    endfunction

    function automatic int active_height();
        int h;
        h = frame_height;
        if (h < 2)
            h = 2;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        return h;
    endfunction

    // floor shift by 8 and saturate to a byte
    function automatic logic [7:0] sat8(int acc);
        int v;
        v = acc >>> 8;
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // one raw byte: update the stores and position, queue any pixels it makes
    task automatic convert_byte(input logic [7:0] b, input logic sof);
        int groups;
        int height;
        int col;
        int uidx;
        int cu;
        int cv;
        int yy;
        int n;
        logic [7:0] y;
        logic [7:0] v;
        bit frame_end;
        rgb_pixel_t px;
        groups = active_width() >> 2;
        height = active_height();
        if (sof) begin
            byte_pos  = 0;
            group_idx = 0;
            line_idx  = 0;
            line_odd  = 1'b0;
        end
        if (!line_odd) begin
            if (byte_pos < 4)
                even_luma[group_idx*4 + byte_pos] = b;
            else
                even_u[group_idx*2 + byte_pos - 4] = b;
        end else if (byte_pos < 4) begin
            odd_luma[byte_pos*8 +: 8] = b;
        end else if (byte_pos == 4) begin
            first_v = b;
        end else begin
            frame_end = (group_idx + 1 >= groups) && (line_idx + 2 >= height);
            n = 0;
            for (int row = 0; row < 2; row++) begin
                for (int k = 0; k < 4; k++) begin
                    col  = group_idx*4 + k;
                    uidx = group_idx*2 + k/2;
                    y    = (row == 0) ? even_luma[col] : odd_luma[k*8 +: 8];
                    v    = (k < 2) ? first_v : b;
                    cu   = int'(even_u[uidx]) - 128;
                    cv   = int'(v) - 128;
                    yy   = int'(y) * 256;
                    px.red          = sat8(yy + 359*cv);
                    px.green        = sat8(yy - 88*cu - 183*cv);
                    px.blue         = sat8(yy + 454*cu);
                    px.odd_row      = (row == 1);
                    px.column       = col[COLUMN_W-1:0];
                    px.row_pair     = line_idx[ROW_PAIR_W:1];
                    px.last_of_run  = (n == 7);
                    px.end_of_frame = (n == 7) && frame_end;
                    predicted_pixels.push_back(px);
                    n++;
                end
            end
        end
        // advance to the next byte, line and frame
        if (byte_pos >= 5) begin
            byte_pos = 0;
            if (group_idx + 1 >= groups) begin
                group_idx = 0;
                if (line_idx + 1 >= height) begin
                    line_idx = 0;
                    line_odd = 1'b0;
                end else begin
                    line_idx = line_idx + 1;
                    line_odd = line_idx[0];
                end
            end else begin
                group_idx++;
            end
        end else begin
            byte_pos++;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            pixel_errors++;
            if (pixel_errors <= 10)
                $display("pixel %0d: %s expected %0d, got %0d", pixels_seen, name, want,
                         got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            line_width   = LINE_WIDTH_RST;
            frame_height = FRAME_HEIGHT_RST;
            odd_luma     = '0;
            first_v      = '0;
            byte_pos     = 0;
            group_idx    = 0;
            line_idx     = 0;
            line_odd     = 1'b0;
            pixels_seen  = 0;
            pixel_errors = 0;
            predicted_pixels.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                if (cfg_addr == REG_LINE_WIDTH)
                    line_width = cfg_wdata;
                else if (cfg_addr == REG_FRAME_HEIGHT)
                    frame_height = cfg_wdata;
            end
            // byte transfer
            if (s_tvalid && s_tready)
                convert_byte(s_tdata, s_tuser);
            // pixel transfer
            if (m_tvalid && m_tready) begin
                if (predicted_pixels.size() == 0) begin
                    pixel_errors++;
                    if (pixel_errors <= 10)
                        $display("pixel %0d: not predicted, data %h", pixels_seen, m_tdata);
                end else begin
                    rgb_pixel_t want;
                    want = predicted_pixels.pop_front();
                    check_field("red", want.red, m_tdata[7:0]);
                    check_field("green", want.green, m_tdata[15:8]);
                    check_field("blue", want.blue, m_tdata[23:16]);
                    check_field("odd_row", want.odd_row, m_tdata[24]);
                    check_field("column", want.column, m_tdata[34:25]);
                    check_field("row_pair", want.row_pair, m_tdata[43:35]);
                    check_field("last_of_run", want.last_of_run, m_tlast);
                    check_field("end_of_frame", want.end_of_frame, m_tuser);
                end
                pixels_seen++;
            end
        end
        pixels_outstanding = predicted_pixels.size();
    end

endmodule

FILE: test/interleaved_yuv420_to_rgb_tb.sv
// ----------------------------------------------------------------------------
// interleaved_yuv420_to_rgb_tb
// Feeds raw interleaved 4:2:0 bytes into the converter under several line
// widths and frame heights, with random idle cycles on both channels, while
// rgb_pixel_checker predicts and checks every pixel.
// ----------------------------------------------------------------------------
module interleaved_yuv420_to_rgb_tb;
    import iyrgb_pkg::*;

    localparam int TIMEOUT = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [47:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int pixel_errors;
    int pixels_outstanding;

    always #1 aclk = ~aclk;

    interleaved_yuv420_to_rgb dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    rgb_pixel_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_tvalid           (s_tvalid),
        .s_tready           (s_tready),
        .s_tdata            (s_tdata),
        .s_tuser            (s_tuser),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tlast            (m_tlast),
        .m_tuser            (m_tuser),
        .pixel_errors       (pixel_errors),
        .pixels_outstanding (pixels_outstanding)
    );

    // receiver stalls
    always @(negedge aclk)
        m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

    // run limit
    initial begin
        #TIMEOUT;
        $display("Mismatches found");
        $finish;
    end

    task automatic set_geometry(input logic [CFG_W-1:0] width,
                                input logic [CFG_W-1:0] height);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_LINE_WIDTH;
        cfg_wdata <= width;
        @(negedge aclk);
        cfg_addr  <= REG_FRAME_HEIGHT;
        cfg_wdata <= height;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic sof);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
    endtask

    // wait for every predicted pixel, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pixels_outstanding != 0)
            @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    task automatic send_group(input logic [7:0] y0, input logic [7:0] y1,
                              input logic [7:0] y2, input logic [7:0] y3,
                              input logic [7:0] c0, input logic [7:0] c1,
                              input logic sof);
        send_byte(y0, sof);
        send_byte(y1, 1'b0);
        send_byte(y2, 1'b0);
        send_byte(y3, 1'b0);
        send_byte(c0, 1'b0);
        send_byte(c1, 1'b0);
    endtask

    // byte values lean toward the ends of the range to drive clamping
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // random frame content, optionally with stray start-of-frame marks
    task automatic random_bytes(input int count, input bit sof_first, input bit noise,
                                input int pause_at);
        logic sof;
        for (int i = 0; i < count; i++) begin
            if (i == pause_at)
                drain();
            if (i == 0)
                sof = sof_first;
            else
                sof = noise && ($urandom_range(99) < 4);
            send_byte(pick_byte(), sof);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_LINE_WIDTH;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // smallest frame: luma and chroma extremes, then neutral U with extreme V
        set_geometry(11'd4, 11'd2);
        send_group(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 1'b1);
        send_group(8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
        send_group(8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 8'd128, 1'b1);
        send_group(8'd16, 8'd235, 8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
        drain();

        // odd height, the unpaired line is dropped and the frame wraps
        set_geometry(11'd8, 11'd3);
        random_bytes(36, 1'b1, 1'b1, -1);
        drain();

        // both registers below range, sender mostly idle
        send_idle_pct = 88;
        set_geometry(11'd3, 11'd1);
        random_bytes(18, 1'b1, 1'b1, -1);
        drain();

        // width rounded down, height above range, receiver mostly stalled;
        // ends inside a later group of line two
        send_idle_pct = 0;
        stall_pct     = 88;
        set_geometry(11'd14, 11'd2047);
        random_bytes(44, 1'b1, 1'b0, 20);
        drain();

        // shrink to one group without resync: the line ends at once
        send_idle_pct = 26;
        stall_pct     = 26;
        set_geometry(11'd0, 11'd0);
        random_bytes(18, 1'b0, 1'b1, -1);
        drain();

        // widest line: first even-line group only, no pixels come out
        set_geometry(11'd2047, 11'd2);
        random_bytes(6, 1'b1, 1'b0, -1);
        drain();

        if (pixel_errors == 0 && pixels_outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: interleaved_yuv420_to_rgb.f
rtl/core/iyrgb_pkg.sv
rtl/core/iyrgb_ram.sv
rtl/core/iyrgb_parser.sv
rtl/core/iyrgb_emitter.sv
rtl/core/interleaved_yuv420_to_rgb.sv
test/rgb_pixel_checker.sv
test/interleaved_yuv420_to_rgb_tb.sv
